// ===== design/bftr_pkg.sv =====
// Shared types and constants of the bitmap font text rasterizer.
// Used by the glyph ROM, the raster engine and the top level; depends on nothing.
`default_nettype none

package bftr_pkg;

	// Font geometry.
	localparam int GLYPH_W       = 5;
	localparam int GLYPH_H       = 7;
	localparam int GLYPH_COUNT   = 26;
	localparam int GLYPH_ADVANCE = 6;
	localparam int LINE_PITCH    = 8;
	localparam int ROM_DEPTH     = GLYPH_COUNT * GLYPH_H;
	localparam int ROM_AW        = $clog2(ROM_DEPTH);

	// Character codes with a meaning of their own.
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = CH_LOWER_A - CH_UPPER_A;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_TEXT_COLOR = 2'd0,
		REG_TEXT_SCALE = 2'd1,
		REG_START_X    = 2'd2,
		REG_START_Y    = 2'd3
	} reg_index_t;

	// Glyph draw command from the cursor logic to the raster engine.
	typedef struct packed {
		logic               start;
		logic [4:0]         glyph;
		logic signed [15:0] base_x;
		logic signed [15:0] base_y;
		logic [7:0]         scale;
		logic [15:0]        color;
	} draw_cmd_t;

endpackage

`default_nettype wire

// ===== design/bftr_glyph_rom.sv =====
// Synchronous 5x7 font ROM, 26 upper-case glyphs of 7 rows each.
// One read per cycle into a registered output; uses bftr_pkg.
`default_nettype none

module bftr_glyph_rom (
	input  wire logic                       clk,
	input  wire logic                       rd_en,
	input  wire logic [bftr_pkg::ROM_AW-1:0] addr,
	output logic [bftr_pkg::GLYPH_W-1:0]    data
);
	import bftr_pkg::*;

	localparam logic [GLYPH_W-1:0] GLYPH_ROM [ROM_DEPTH] = '{
		5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11,
		5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E,
		5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E,
		5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E,
		5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F,
		5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10,
		5'h0E, 5'h11, 5'h10, 5'h10, 5'h13, 5'h11, 5'h0F,
		5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11,
		5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F,
		5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E,
		5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11,
		5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F,
		5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11,
		5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11,
		5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E,
		5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10,
		5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D,
		5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11,
		5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E,
		5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04,
		5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E,
		5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04,
		5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A,
		5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11,
		5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04,
		5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F
	};

	logic [GLYPH_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (32'(addr) < ROM_DEPTH) begin
				data_q <= GLYPH_ROM[addr];
			end else begin
				data_q <= '0;
			end
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

// ===== design/bftr_raster.sv =====
// Raster engine: walks the 5x7 cell one glyph pixel per cycle out of the glyph ROM while the
// output does not stall, clips each set pixel's rectangle and emits it. Uses bftr_pkg and bftr_glyph_rom.
`default_nettype none

module bftr_raster #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 820
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bftr_pkg::draw_cmd_t cmd,
	output logic                     busy,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [8:0]               rect_x,
	output logic [9:0]               rect_y,
	output logic [7:0]               rect_width,
	output logic [7:0]               rect_height,
	output logic [15:0]              fill_color,
	output logic                     last_rect
);
	import bftr_pkg::*;

	localparam logic signed [17:0] X_LIM = 18'(SCREEN_WIDTH);
	localparam logic signed [17:0] Y_LIM = 18'(SCREEN_HEIGHT);
	localparam logic [2:0] COL_LAST = 3'(GLYPH_W - 1);
	localparam logic [2:0] ROW_LAST = 3'(GLYPH_H - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t state_q;
	logic [2:0]  row_q, col_q;
	logic [9:0]  x_off_q;
	logic [10:0] y_off_q;
	logic [ROM_AW-1:0] addr_q;
	logic signed [15:0] base_x_q, base_y_q;
	logic [7:0]  scale_q;
	logic [15:0] color_q;

	// Pending rectangle: held back until the next one shows whether it was the last.
	logic        pend_v_q;
	logic [8:0]  pend_x_q;
	logic [9:0]  pend_y_q;
	logic [7:0]  pend_w_q, pend_h_q;
	logic [15:0] pend_c_q;

	logic        out_v_q, out_last_q;
	logic [8:0]  out_x_q;
	logic [9:0]  out_y_q;
	logic [7:0]  out_w_q, out_h_q;
	logic [15:0] out_c_q;

	logic [GLYPH_W-1:0] rom_data;
	logic               rom_rd;
	logic [ROM_AW-1:0]  rom_addr, start_addr;

	logic signed [17:0] s_ext, x0, x1, y0, y1, x0c, x1c, y0c, y1c, w_diff, h_diff;
	logic pix_bit, scan_hit, out_free, advance, col_end, last_px, load_out;

	assign start_addr = ROM_AW'(cmd.glyph) * ROM_AW'(GLYPH_H);

	always_comb begin
		s_ext   = $signed({10'd0, scale_q});
		x0      = 18'(base_x_q) + $signed({8'd0, x_off_q});
		y0      = 18'(base_y_q) + $signed({7'd0, y_off_q});
		x1      = x0 + s_ext;
		y1      = y0 + s_ext;
		x0c     = x0[17] ? '0 : x0;
		y0c     = y0[17] ? '0 : y0;
		x1c     = (x1 > X_LIM) ? X_LIM : x1;
		y1c     = (y1 > Y_LIM) ? Y_LIM : y1;
		w_diff  = x1c - x0c;
		h_diff  = y1c - y0c;
		pix_bit = rom_data[3'(COL_LAST - col_q)];
		scan_hit = (state_q == ST_SCAN) && pix_bit && (x1c > x0c) && (y1c > y0c);
		out_free = !out_v_q || out_ready;
		advance  = (state_q == ST_SCAN) && (!scan_hit || !pend_v_q || out_free);
		col_end  = (col_q == COL_LAST);
		last_px  = col_end && (row_q == ROW_LAST);
		load_out = (advance && scan_hit && pend_v_q) ||
			((state_q == ST_FLUSH) && pend_v_q && out_free);
	end

	// The ROM output register holds a row until the scan moves past its last column.
	always_comb begin
		rom_rd   = 1'b0;
		rom_addr = addr_q + 1'b1;
		if (state_q == ST_IDLE && cmd.start) begin
			rom_rd   = 1'b1;
			rom_addr = start_addr;
		end else if (advance && col_end && !last_px) begin
			rom_rd = 1'b1;
		end
	end

	bftr_glyph_rom u_rom (
		.clk   (clk),
		.rd_en (rom_rd),
		.addr  (rom_addr),
		.data  (rom_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q  <= ST_SCAN;
						row_q    <= '0;
						col_q    <= '0;
						x_off_q  <= '0;
						y_off_q  <= '0;
						addr_q   <= start_addr;
						base_x_q <= cmd.base_x;
						base_y_q <= cmd.base_y;
						scale_q  <= cmd.scale;
						color_q  <= cmd.color;
					end
				end
				ST_SCAN: begin
					if (advance) begin
						if (scan_hit) begin
							if (pend_v_q) begin
								out_last_q <= 1'b0;
								out_x_q    <= pend_x_q;
								out_y_q    <= pend_y_q;
								out_w_q    <= pend_w_q;
								out_h_q    <= pend_h_q;
								out_c_q    <= pend_c_q;
							end
							pend_v_q <= 1'b1;
							pend_x_q <= x0c[8:0];
							pend_y_q <= y0c[9:0];
							pend_w_q <= w_diff[7:0];
							pend_h_q <= h_diff[7:0];
							pend_c_q <= color_q;
						end
						if (col_end) begin
							col_q   <= '0;
							x_off_q <= '0;
							row_q   <= row_q + 1'b1;
							y_off_q <= y_off_q + {3'd0, scale_q};
							addr_q  <= addr_q + 1'b1;
						end else begin
							col_q   <= col_q + 1'b1;
							x_off_q <= x_off_q + {2'd0, scale_q};
						end
						if (last_px) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_last_q <= 1'b1;
						out_x_q    <= pend_x_q;
						out_y_q    <= pend_y_q;
						out_w_q    <= pend_w_q;
						out_h_q    <= pend_h_q;
						out_c_q    <= pend_c_q;
						pend_v_q   <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign out_valid   = out_v_q;
	assign rect_x      = out_x_q;
	assign rect_y      = out_y_q;
	assign rect_width  = out_w_q;
	assign rect_height = out_h_q;
	assign fill_color  = out_c_q;
	assign last_rect   = out_last_q;

endmodule

`default_nettype wire

// ===== design/bitmap_font_text_rasterizer.sv =====
// Top level: configuration registers, text cursor and the raster engine. A letter keeps
// the engine busy from acceptance over its 35 glyph pixels (one per cycle from the glyph
// ROM register, held while the output is stalled) and the flush; other codes leave input
// ready. Each rectangle passes a pending and an output register; one is held back.
// Reset: color 0, scale 1, start point and cursor at 0, output empty, ready for input.
// Uses bftr_pkg and bftr_raster.
`default_nettype none

module bitmap_font_text_rasterizer #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 820
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_code,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [8:0]       rect_x,
	output logic [9:0]       rect_y,
	output logic [7:0]       rect_width,
	output logic [7:0]       rect_height,
	output logic [15:0]      fill_color,
	output logic             last_rect
);
	import bftr_pkg::*;

	logic [15:0] text_color_q, start_x_q, cursor_col_q, cursor_row_q;
	logic [7:0]  text_scale_q, scale_eff, folded;
	logic        engine_busy, accept, is_letter;
	logic [10:0] advance_step, line_step;
	draw_cmd_t   cmd;

	assign in_ready = !engine_busy;
	assign accept   = in_valid && in_ready;

	always_comb begin
		scale_eff    = (text_scale_q == 8'd0) ? 8'd1 : text_scale_q;
		advance_step = 11'(scale_eff) * 11'(GLYPH_ADVANCE);
		line_step    = 11'(scale_eff) * 11'(LINE_PITCH);
		folded       = char_code;
		if (char_code inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
			folded = char_code - CASE_OFFSET;
		end
		is_letter    = (folded inside {[CH_UPPER_A:CH_UPPER_Z]});
		cmd.start    = accept && is_letter;
		cmd.glyph    = 5'(folded - CH_UPPER_A);
		cmd.base_x   = $signed(cursor_col_q);
		cmd.base_y   = $signed(cursor_row_q);
		cmd.scale    = scale_eff;
		cmd.color    = text_color_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= '0;
			text_scale_q <= 8'd1;
			start_x_q    <= '0;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
		end else begin
			if (cfg_write) begin
				case (reg_index_t'(cfg_index))
					REG_TEXT_COLOR: text_color_q <= cfg_data;
					REG_TEXT_SCALE: text_scale_q <= cfg_data[7:0];
					REG_START_X: begin
						start_x_q    <= cfg_data;
						cursor_col_q <= cfg_data;
					end
					REG_START_Y: begin
						cursor_row_q <= cfg_data;
					end
					default: ;
				endcase
			end else if (accept) begin
				if (char_code == CH_LF) begin
					cursor_col_q <= start_x_q;
					cursor_row_q <= cursor_row_q + {5'd0, line_step};
				end else if (char_code != CH_CR) begin
					// Every code other than the two controls moves the cursor on.
					cursor_col_q <= cursor_col_q + {5'd0, advance_step};
				end
			end
		end
	end

	bftr_raster #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_raster (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.busy        (engine_busy),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.rect_x      (rect_x),
		.rect_y      (rect_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.fill_color  (fill_color),
		.last_rect   (last_rect)
	);

endmodule

`default_nettype wire

// ===== tb/rect_checker.sv =====
// Checker for the bitmap font text rasterizer: tracks register writes and accepted character
// words, predicts the rectangles each word yields and compares them with the output channel.
// Depends on bftr_pkg for the register indexes, character codes and font geometry.
module rect_checker
	import bftr_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 820
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [7:0]  char_code,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [8:0]  rect_x,
	input  wire logic [9:0]  rect_y,
	input  wire logic [7:0]  rect_width,
	input  wire logic [7:0]  rect_height,
	input  wire logic [15:0] fill_color,
	input  wire logic        last_rect,
	output int               error_count,
	output int               pending_count
);

	typedef struct {
		logic [8:0]  x;
		logic [9:0]  y;
		logic [7:0]  w;
		logic [7:0]  h;
		logic [15:0] color;
		logic        last_flag;
	} rect_t;

	localparam int MAX_PRINTED = 20;

	rect_t       expected_rects[$];
	rect_t       oldest_rect;
	int          errors = 0;
	int          outstanding = 0;

	logic [15:0] pen_color;
	logic [7:0]  pen_scale;
	logic [15:0] origin_x;
	logic [15:0] cursor_col;
	logic [15:0] cursor_row;

	assign error_count   = errors;
	assign pending_count = outstanding;

	// Each glyph is packed as seven 5-bit rows, top row in the upper bits.
	function automatic logic [34:0] glyph_bits(input int letter);
		case (letter)
			0:  return {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
			1:  return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
			2:  return {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
			3:  return {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
			4:  return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
			5:  return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
			6:  return {5'h0E, 5'h11, 5'h10, 5'h10, 5'h13, 5'h11, 5'h0F};
			7:  return {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
			8:  return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
			9:  return {5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E};
			10: return {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
			11: return {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
			12: return {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
			13: return {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
			14: return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
			15: return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
			16: return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
			17: return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
			18: return {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
			19: return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
			20: return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
			21: return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
			22: return {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
			23: return {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
			24: return {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
			25: return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
			default: return '0;
		endcase
	endfunction

	task automatic report_error(input string msg);
		errors++;
		if (errors <= MAX_PRINTED)
			$display("ERROR %0t: %s", $time, msg);
	endtask

	// Moves the cursor for one character word and queues the rectangles it draws.
	task automatic rasterize_char(input logic [7:0] code);
		logic [7:0]  c;
		logic [34:0] bits;
		int          s;
		int          bx;
		int          by;
		int          x0;
		int          y0;
		int          x1;
		int          y1;
		rect_t       r;
		rect_t       glyph_rects[$];
		s = (pen_scale == 8'd0) ? 1 : int'(pen_scale);
		if (code == CH_LF) begin
			cursor_col = origin_x;
			cursor_row = cursor_row + 16'(LINE_PITCH * s);
		end else if (code != CH_CR) begin
			c = code;
			if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
				c = c - CASE_OFFSET;
			if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
				bits = glyph_bits(int'(c - CH_UPPER_A));
				bx = $signed(cursor_col);
				by = $signed(cursor_row);
				for (int row = 0; row < GLYPH_H; row++) begin
					for (int col = 0; col < GLYPH_W; col++) begin
						if (bits[34 - GLYPH_W * row - col]) begin
							x0 = bx + col * s;
							y0 = by + row * s;
							x1 = x0 + s;
							y1 = y0 + s;
							if (x0 < 0) x0 = 0;
							if (y0 < 0) y0 = 0;
							if (x1 > SCREEN_WIDTH) x1 = SCREEN_WIDTH;
							if (y1 > SCREEN_HEIGHT) y1 = SCREEN_HEIGHT;
							if (x1 > x0 && y1 > y0) begin
								r.x = x0[8:0];
								r.y = y0[9:0];
								r.w = 8'(x1 - x0);
								r.h = 8'(y1 - y0);
								r.color = pen_color;
								r.last_flag = 1'b0;
								glyph_rects.push_back(r);
							end
						end
					end
				end
				if (glyph_rects.size() > 0)
					glyph_rects[glyph_rects.size() - 1].last_flag = 1'b1;
				foreach (glyph_rects[i])
					expected_rects.push_back(glyph_rects[i]);
			end
			cursor_col = cursor_col + 16'(GLYPH_ADVANCE * s);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_color  = 16'd0;
			pen_scale  = 8'd1;
			origin_x   = 16'd0;
			cursor_col = 16'd0;
			cursor_row = 16'd0;
			expected_rects.delete();
			outstanding <= 0;
		end else begin
			if (cfg_write) begin
				case (reg_index_t'(cfg_index))
					REG_TEXT_COLOR: pen_color = cfg_data;
					REG_TEXT_SCALE: pen_scale = cfg_data[7:0];
					REG_START_X: begin
						origin_x   = cfg_data;
						cursor_col = cfg_data;
					end
					REG_START_Y: begin
						cursor_row = cfg_data;
					end
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				rasterize_char(char_code);
			if (out_valid && out_ready) begin
				if (expected_rects.size() == 0) begin
					report_error($sformatf("rectangle x=%0d y=%0d with nothing expected",
						rect_x, rect_y));
				end else begin
					oldest_rect = expected_rects.pop_front();
					if (rect_x !== oldest_rect.x)
						report_error($sformatf("rect_x %0d, expected %0d",
							rect_x, oldest_rect.x));
					if (rect_y !== oldest_rect.y)
						report_error($sformatf("rect_y %0d, expected %0d",
							rect_y, oldest_rect.y));
					if (rect_width !== oldest_rect.w)
						report_error($sformatf("rect_width %0d, expected %0d",
							rect_width, oldest_rect.w));
					if (rect_height !== oldest_rect.h)
						report_error($sformatf("rect_height %0d, expected %0d",
							rect_height, oldest_rect.h));
					if (fill_color !== oldest_rect.color)
						report_error($sformatf("fill_color %h, expected %h",
							fill_color, oldest_rect.color));
					if (last_rect !== oldest_rect.last_flag)
						report_error($sformatf("last_rect %b, expected %b",
							last_rect, oldest_rect.last_flag));
				end
			end
			outstanding <= expected_rects.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the rasterizer testbench: clock, reset, register writes, character stimulus
// and output back-pressure, with the verdict taken from the checker's error count.
// Depends on bftr_pkg, bitmap_font_text_rasterizer and rect_checker.
module testbench;
	import bftr_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 50;
	localparam int HOLD_CYCLES  = 400;
	localparam int SEGMENTS     = 12;
	localparam int SEG_WORDS    = 40;
	localparam int QUIET_SEG    = 4;
	localparam int HOLD_SEG     = 7;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  char_code;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [8:0]  rect_x;
	logic [9:0]  rect_y;
	logic [7:0]  rect_width;
	logic [7:0]  rect_height;
	logic [15:0] fill_color;
	logic        last_rect;

	int          error_count;
	int          pending_count;
	int          cycle_count = 0;
	int          hold_left = 0;
	logic        hold_done = 1'b0;
	logic        hold_req = 1'b0;
	logic        quiet = 1'b0;

	bitmap_font_text_rasterizer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_code   (char_code),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.rect_x      (rect_x),
		.rect_y      (rect_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.fill_color  (fill_color),
		.last_rect   (last_rect)
	);

	rect_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.char_code     (char_code),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.rect_x        (rect_x),
		.rect_y        (rect_y),
		.rect_width    (rect_width),
		.rect_height   (rect_height),
		.fill_color    (fill_color),
		.last_rect     (last_rect),
		.error_count   (error_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Receiver: rare random stalls, none in the quiet segment, and one long hold-off.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_ready <= quiet || ($urandom_range(99) >= 6);
		end
	end

	// Offers one word and returns at the edge that accepts it, leaving valid high so
	// that a following word can be offered back to back.
	task automatic send_char(input logic [7:0] code);
		int gap;
		gap = 0;
		while (!quiet && $urandom_range(99) < 6)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= code;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic wait_drained(input int extra);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// A glyph with no visible pixel gives no result, so the extra cycles let the engine
	// finish before the registers change.
	task automatic configure(input logic [15:0] color, input logic [7:0] scale,
			input logic [15:0] sx, input logic [15:0] sy);
		wait_drained(DRAIN_CYCLES);
		write_reg(REG_TEXT_COLOR, color);
		write_reg(REG_TEXT_SCALE, {8'($urandom), scale});
		write_reg(REG_START_X, sx);
		write_reg(REG_START_Y, sy);
		cfg_write <= 1'b0;
	endtask

	function automatic logic [7:0] random_letter();
		logic [7:0] c;
		c = CH_UPPER_A + 8'($urandom_range(25));
		if ($urandom_range(1) == 1)
			c = c + CASE_OFFSET;
		return c;
	endfunction

	function automatic logic [7:0] random_code();
		int pick;
		pick = $urandom_range(99);
		if (pick < 55)
			return random_letter();
		else if (pick < 65)
			return CH_LF;
		else if (pick < 70)
			return CH_CR;
		else
			return 8'($urandom_range(255));
	endfunction

	task automatic random_setting();
		logic [7:0]  scale;
		logic [15:0] sx;
		logic [15:0] sy;
		case ($urandom_range(9))
			0:       scale = 8'd0;
			1:       scale = 8'd255;
			2:       scale = 8'($urandom_range(255));
			default: scale = 8'($urandom_range(4, 1));
		endcase
		if ($urandom_range(9) == 0)
			sx = 16'($urandom);
		else
			sx = 16'($urandom_range(350) - 20);
		if ($urandom_range(9) == 0)
			sy = 16'($urandom);
		else
			sy = 16'($urandom_range(850) - 20);
		configure(16'($urandom), scale, sx, sy);
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_TEXT_COLOR;
		cfg_data  = 16'd0;
		in_valid  = 1'b0;
		char_code = 8'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: folding, control codes and the codes around the letter ranges.
		send_char("A");
		send_char("z");
		send_char(CH_CR);
		send_char("B");
		send_char(CH_LF);
		send_char("m");
		send_char(" ");
		send_char("0");
		send_char(8'h00);
		send_char(8'hFF);
		send_char(8'h40);
		send_char(8'h5B);
		send_char(8'h60);
		send_char(8'h7B);

		// Scale zero at the lower right corner: clipped on both far edges.
		configure(16'hFFFF, 8'd0, 16'd316, 16'd815);
		send_char("W");
		send_char("H");

		// Largest scale from the most negative corner: nothing is visible.
		configure(16'hA5A5, 8'd255, 16'h8000, 16'h8000);
		send_char("A");
		send_char(CH_LF);
		send_char("Q");

		configure(16'h5A5A, 8'd255, 16'd200, 16'd700);
		send_char("E");

		// Partly left of the screen.
		configure(16'h0F0F, 8'd2, 16'hFFF8, 16'hFFFA);
		send_char("K");
		send_char("X");

		// The cursor column wraps from a large positive to a negative value.
		configure(16'h0000, 8'd255, 16'h7F00, 16'd0);
		send_char("I");
		send_char("I");

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg == HOLD_SEG)
				configure(16'($urandom), 8'd1, 16'd0, 16'd0);
			else
				random_setting();
			quiet    = (seg == QUIET_SEG);
			hold_req = (seg == HOLD_SEG);
			for (int i = 0; i < SEG_WORDS; i++) begin
				send_char((seg == HOLD_SEG) ? random_letter() : random_code());
				if (!quiet && $urandom_range(39) == 0)
					wait_drained(0);
			end
		end
		quiet = 1'b0;

		wait_drained(DRAIN_CYCLES);
		if (error_count == 0 && pending_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
